// ===== hw/rtl/pbtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbtm_pkg
// Shared types and codes of the heater-off trimmed-mean sampler.
// ----------------------------------------------------------------------------
package pbtm_pkg;

    localparam int ADC_W   = 12;
    localparam int FUNC_W  = 2;
    localparam int STATE_W = 3;

    // Function codes carried with each input word
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ACK    = 2'd2;

    // Measurement sequencer phases
    typedef enum logic [STATE_W-1:0] {
        PH_IDLE      = 3'd0,
        PH_REQUESTED = 3'd1,
        PH_STOPPED   = 3'd2,
        PH_SAMPLING  = 3'd3,
        PH_READY     = 3'd4
    } pbtm_phase_t;

    // One result word
    typedef struct packed {
        logic               average_new;
        logic [ADC_W-1:0]   average;
        pbtm_phase_t        measure_state;
        logic               pwm_enable;
    } pbtm_result_t;

endpackage

// ===== hw/rtl/pbtm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbtm_div
// Truncating division by a fixed divisor through a reciprocal multiply.
// ----------------------------------------------------------------------------
module pbtm_div
    import pbtm_pkg::*;
#(
    parameter int NUM_W = 16,
    parameter int DIV   = 14
) (
    input  logic [NUM_W-1:0] num,
    output logic [ADC_W-1:0] quo
);

    // floor(n * MULT / 2^SHIFT) equals floor(n / DIV) for every n below 2^NUM_W
    localparam int           LOG_D = $clog2(DIV);
    localparam int           SHIFT = NUM_W + LOG_D;
    localparam int           MUL_W = NUM_W + 1;
    localparam logic [63:0]  MULT_WIDE = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / DIV;
    localparam logic [MUL_W-1:0] MULT = MULT_WIDE[MUL_W-1:0];
    localparam int           PROD_W = NUM_W + MUL_W;

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(num) * PROD_W'(MULT);
    assign quo  = prod[SHIFT +: ADC_W];

endmodule

// ===== hw/rtl/pbtm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbtm_ctrl
// Measurement sequencer, pass counter and running sum, minimum and maximum.
// ----------------------------------------------------------------------------
module pbtm_ctrl
    import pbtm_pkg::*;
#(
    parameter int SAMPLES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  logic [FUNC_W-1:0]  func,
    input  logic [ADC_W-1:0]   sample,
    output pbtm_result_t       result
);

    localparam int IDX_W = $clog2(SAMPLES);
    localparam int SUM_W = ADC_W + $clog2(SAMPLES);
    localparam logic [IDX_W-1:0] IDX_HALF = IDX_W'(SAMPLES / 2 - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES - 1);

    pbtm_phase_t       phase_reg, phase_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SUM_W-1:0]  sum_reg, sum_next, sum_upd;
    logic [ADC_W-1:0]  min_reg, min_next, min_upd;
    logic [ADC_W-1:0]  max_reg, max_next, max_upd;
    logic [ADC_W-1:0]  avg_reg, avg_next, avg_calc;
    logic              heater_reg, heater_next;
    logic              fresh;
    logic [SUM_W-1:0]  trimmed;

    // Running values including the current sample
    always_comb begin
        sum_upd = sum_reg + SUM_W'(sample);
        max_upd = (sample > max_reg) ? sample : max_reg;
        min_upd = (sample < min_reg) ? sample : min_reg;
    end

    assign trimmed = sum_upd - SUM_W'(min_upd) - SUM_W'(max_upd);

    pbtm_div #(
        .NUM_W (SUM_W),
        .DIV   (SAMPLES - 2)
    ) u_div (
        .num (trimmed),
        .quo (avg_calc)
    );

    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        avg_next    = avg_reg;
        heater_next = heater_reg;
        fresh       = 1'b0;
        if (fire) begin
            case (func)
                FUNC_TICK: begin
                    if (phase_reg == PH_IDLE) phase_next = PH_REQUESTED;
                end
                FUNC_SAMPLE: begin
                    if (phase_reg == PH_SAMPLING) begin
                        sum_next = sum_upd;
                        min_next = min_upd;
                        max_next = max_upd;
                    end
                    // Stop the heater half-way through a pass
                    if (idx_reg == IDX_HALF && phase_reg == PH_REQUESTED) begin
                        heater_next = 1'b0;
                        phase_next  = PH_STOPPED;
                    end
                    if (idx_reg == IDX_LAST) begin
                        if (phase_reg == PH_STOPPED) begin
                            sum_next   = '0;
                            min_next   = '1;
                            max_next   = '0;
                            phase_next = PH_SAMPLING;
                        end else if (phase_reg == PH_SAMPLING) begin
                            heater_next = 1'b1;
                            avg_next    = avg_calc;
                            phase_next  = PH_READY;
                            fresh       = 1'b1;
                        end
                        idx_next = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                FUNC_ACK: begin
                    if (phase_reg == PH_READY) phase_next = PH_IDLE;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            idx_reg    <= '0;
            sum_reg    <= '0;
            min_reg    <= '1;
            max_reg    <= '0;
            avg_reg    <= '0;
            heater_reg <= 1'b1;
        end else begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            sum_reg    <= sum_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            avg_reg    <= avg_next;
            heater_reg <= heater_next;
        end
    end

    always_comb begin
        result.pwm_enable    = heater_next;
        result.measure_state = phase_next;
        result.average       = avg_next;
        result.average_new   = fresh;
    end

endmodule

// ===== hw/rtl/pwm_blanked_trimmed_mean_sampler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_blanked_trimmed_mean_sampler_top
// Heater-off temperature sampler with trimmed-mean average over one pass.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): each word carries a function code in s_tuser
//   (tick, one ADC sample, acknowledge) and a 12-bit sample in s_tdata.
//   Output stream (m_*): exactly one result word per input word, giving
//   PWM enable, measurement state, last average and a new-average flag,
//   all as they stand after that input word.
//   A tick starts a measurement; the heater stops at the half-way sample of
//   a pass, the next full pass is accumulated, and the average
//   (sum - min - max) / (SAMPLES - 2) is published at its end.
//   Path: a word is held in the input register, passes through the
//   sequencer and is registered in the result register, which drives
//   m_*. Throughput: one word per cycle while the receiver does not stall;
//   the state update, running min/max and the reciprocal-multiply divide
//   fit between the two registers.
//   Reset (aresetn low, synchronous): state idle, PWM running, average 0,
//   both stream registers empty.
//   When the receiver stalls the result register holds, the input
//   register fills behind it, and s_tready drops only once both are full.
// ----------------------------------------------------------------------------
module pwm_blanked_trimmed_mean_sampler_top
    import pbtm_pkg::*;
#(
    parameter int SAMPLES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] pwm_enable, [3:1] measure_state,
                                   // [15:4] average, [16] average_new,
                                   // [23:17] zero
);

    logic              in_valid_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [ADC_W-1:0]  sample_reg;
    logic              out_valid_reg;
    pbtm_result_t      result_reg;
    pbtm_result_t      result_next;
    logic              advance;

    // Move the held word on when the result register is free or being emptied
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Input register: capture a word whenever it has room
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg   <= s_tuser;
            sample_reg <= s_tdata[ADC_W-1:0];
        end
    end

    // Sequencer advances once per word leaving the input register
    pbtm_ctrl #(
        .SAMPLES (SAMPLES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (in_valid_reg && advance),
        .func    (func_reg),
        .sample  (sample_reg),
        .result  (result_next)
    );

    // Result register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, result_reg.average_new, result_reg.average,
                       result_reg.measure_state, result_reg.pwm_enable};

    // A fresh average is only ever published together with the ready state
    // and the heater running again
    a_fresh_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && result_reg.average_new) |->
            (result_reg.measure_state == PH_READY && result_reg.pwm_enable))
        else $error("fresh average without ready state and running PWM");

    // The heater is off only while stopped or sampling
    a_pwm_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !result_reg.pwm_enable) |->
            (result_reg.measure_state == PH_STOPPED ||
             result_reg.measure_state == PH_SAMPLING))
        else $error("PWM stopped outside the measurement phases");

    // A word leaving the input register always lands in the result register
    a_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("word lost between input and result registers");

endmodule
